// ===== rtl/core/bfa_pkg.sv =====
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int unsigned FRAMES_DEF    = 262144;
  localparam int unsigned MAX_ORDER_DEF = 11;

  localparam int CMD_W    = 3;
  localparam int FRAME_W  = 18;
  localparam int ORDER_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 19;
  localparam int CFG_W    = 19;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 19'h7FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [CFG_W-1:0] MIN_FRAME_RST = 19'd4096;
  localparam logic [CFG_W-1:0] MAX_FRAME_RST = 19'd262144;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_REF   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_SEED  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FAIL  = 2'd1,
    ST_DROP  = 2'd2,
    ST_DFREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_FRAME = 2'd0,
    REG_MAX_FRAME = 2'd1,
    REG_RC_ENABLE = 2'd2
  } reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] min_frame;
    logic [CFG_W-1:0] max_frame;
    logic             rc_enable;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame;
    logic [ORDER_W-1:0] order;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] block_frame;
    logic [COUNT_W-1:0] count_value;
    logic [TOTAL_W-1:0] free_frames;
    logic               duplicate_owner;
  } res_t;

endpackage

// ===== rtl/core/bfa_if.sv =====
`timescale 1ns / 1ps
interface bfa_req_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::CMD_W-1:0]    command;
  logic [bfa_pkg::FRAME_W-1:0]  frame;
  logic [bfa_pkg::ORDER_W-1:0]  order;

  modport source (output valid, command, frame, order, input ready);
  modport sink   (input valid, command, frame, order, output ready);
endinterface

interface bfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::FRAME_W-1:0]  block_frame;
  logic [bfa_pkg::COUNT_W-1:0]  count_value;
  logic [bfa_pkg::TOTAL_W-1:0]  free_frames;
  logic                         duplicate_owner;

  modport source (output valid, status, block_frame, count_value, free_frames,
                  duplicate_owner, input ready);
  modport sink   (input valid, status, block_frame, count_value, free_frames,
                  duplicate_owner, output ready);
endinterface

// ===== rtl/core/bfa_ram.sv =====
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/bfa_engine.sv =====
`timescale 1ns / 1ps
module bfa_engine #(
  parameter int unsigned FRAMES    = bfa_pkg::FRAMES_DEF,
  parameter int unsigned MAX_ORDER = bfa_pkg::MAX_ORDER_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfa_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  bfa_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output bfa_pkg::res_t res_o
);
  import bfa_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int CW = (FW + 2 > CFG_W) ? FW + 2 : CFG_W;
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int IW = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
  localparam int LW = FW + 1;
  localparam int SW = FW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_SCAN, S_A_POP, S_A_SPLIT, S_A_PUSH, S_A_DUP,
    S_FILL, S_F_COW, S_F_REL, S_F_MERGE, S_W_CHECK, S_W_NEXT, S_PUSH, S_R_INC,
    S_R_RD, S_FINISH
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [ORDER_W-1:0]  order_q, order_d;
  logic [OW-1:0]       o_q, o_d;
  logic [FW-1:0]       a_q, a_d;
  logic [LW-1:0]       cur_q, cur_d;
  logic [FW-1:0]       prev_q, prev_d;
  logic                hprev_q, hprev_d;
  logic [SW-1:0]       steps_q, steps_d;
  logic [IW-1:0]       i_q, i_d;
  logic                fval_q, fval_d;
  logic                fret_q, fret_d;
  status_e             status_q, status_d;
  logic [FW-1:0]       block_q, block_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                dup_q, dup_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [FW-1:0]       clr_q, clr_d;
  logic [MAX_ORDER-1:0] hv_q, hv_d;
  logic [FW-1:0]       hf_q [MAX_ORDER];
  logic [FW-1:0]       hf_d [MAX_ORDER];

  logic                lk_we;
  logic [FW-1:0]       lk_waddr, lk_raddr;
  logic [LW-1:0]       lk_wdata, lk_rdata;
  logic                rc_we;
  logic [FW-1:0]       rc_waddr, rc_raddr;
  logic [COUNT_W-1:0]  rc_wdata, rc_rdata;

  bfa_ram #(.DEPTH(FRAMES), .WIDTH(LW)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .raddr_i(lk_raddr), .rdata_o(lk_rdata)
  );

  bfa_ram #(.DEPTH(FRAMES), .WIDTH(COUNT_W)) u_count (
    .clk_i, .we_i(rc_we), .waddr_i(rc_waddr), .wdata_i(rc_wdata),
    .raddr_i(rc_raddr), .rdata_o(rc_rdata)
  );

  logic [CW-1:0]        frame_w, order_sz, o_sz, buddy, fill_w;
  logic [FW-1:0]        frame_idx, c_idx;
  logic [HW-1:0]        o_idx;
  logic [LW-1:0]        head_word;
  logic                 order_ok, block_ok, frame_ok;
  logic [TOTAL_W:0]     tsum;
  logic [TOTAL_W-1:0]   t_add, t_sub, t_n;

  always_comb begin
    frame_w   = CW'(frame_q);
    frame_idx = FW'(frame_q);
    order_sz  = CW'(1) << order_q;
    o_sz      = CW'(1) << o_q;
    o_idx     = HW'(o_q);
    head_word = {hv_q[o_idx], hf_q[o_idx]};
    buddy     = CW'(a_q) ^ o_sz;
    c_idx     = cur_q[FW-1:0];
    fill_w    = CW'(a_q) + CW'(i_q);
    order_ok  = {1'b0, order_q} < (ORDER_W + 1)'(MAX_ORDER);
    block_ok  = order_ok && (frame_w + order_sz <= CW'(FRAMES));
    frame_ok  = frame_w < CW'(FRAMES);
    t_n       = TOTAL_W'(order_sz);
    tsum      = {1'b0, total_q} + {1'b0, t_n};
    t_add     = (tsum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[TOTAL_W-1:0];
    t_sub     = (total_q < t_n) ? '0 : total_q - t_n;
  end

  always_comb begin
    state_d  = state_q;  cmd_d   = cmd_q;   frame_d = frame_q; order_d = order_q;
    o_d      = o_q;      a_d     = a_q;     cur_d   = cur_q;   prev_d  = prev_q;
    hprev_d  = hprev_q;  steps_d = steps_q; i_d     = i_q;     fval_d  = fval_q;
    fret_d   = fret_q;   status_d = status_q; block_d = block_q;
    count_d  = count_q;  dup_d   = dup_q;   total_d = total_q; clr_d   = clr_q;
    hv_d     = hv_q;     hf_d    = hf_q;
    lk_we    = 1'b0; lk_waddr = '0; lk_wdata = '0; lk_raddr = '0;
    rc_we    = 1'b0; rc_waddr = '0; rc_wdata = '0; rc_raddr = '0;

    case (state_q)
      S_CLEAR: begin
        rc_we    = 1'b1;
        rc_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == FW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_e'(cmd_i.command);
          frame_d  = cmd_i.frame;
          order_d  = cmd_i.order;
          status_d = ST_FAIL;
          block_d  = '0;
          count_d  = '0;
          dup_d    = 1'b0;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FINISH;
        case (cmd_q)
          CMD_ALLOC: begin
            if (order_ok) begin
              o_d     = OW'(order_q);
              state_d = S_A_SCAN;
            end
          end
          CMD_FREE: begin
            if (block_ok) begin
              if (order_q == '0 && cfg_i.rc_enable) begin
                rc_raddr = frame_idx;
                state_d  = S_F_COW;
              end else begin
                state_d = S_F_REL;
              end
            end
          end
          CMD_REF: begin
            if (frame_ok) begin
              if (cfg_i.rc_enable) begin
                rc_raddr = frame_idx;
                state_d  = S_R_INC;
              end else begin
                status_d = ST_DONE;
              end
            end
          end
          CMD_READ: begin
            if (frame_ok) begin
              status_d = ST_DONE;
              if (cfg_i.rc_enable) begin
                rc_raddr = frame_idx;
                state_d  = S_R_RD;
              end
            end
          end
          CMD_SEED: begin
            if (block_ok) begin
              a_d     = frame_idx;
              o_d     = OW'(order_q);
              total_d = t_add;
              state_d = S_PUSH;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      // search upward for the smallest non-empty list
      S_A_SCAN: begin
        if (o_q == OW'(MAX_ORDER)) begin
          state_d = S_FINISH;
        end else if (hv_q[o_idx]) begin
          a_d      = hf_q[o_idx];
          lk_raddr = hf_q[o_idx];
          state_d  = S_A_POP;
        end else begin
          o_d = o_q + 1'b1;
        end
      end
      S_A_POP: begin
        hv_d[o_idx] = lk_rdata[FW];
        hf_d[o_idx] = lk_rdata[FW-1:0];
        state_d     = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (o_q > OW'(order_q)) begin
          o_d     = o_q - 1'b1;
          state_d = S_A_PUSH;
        end else begin
          total_d  = t_sub;
          block_d  = a_q;
          status_d = ST_DONE;
          state_d  = S_FINISH;
          if (cfg_i.rc_enable) begin
            i_d    = '0;
            fval_d = 1'b1;
            fret_d = 1'b0;
            if (order_q == '0) begin
              rc_raddr = a_q;
              state_d  = S_A_DUP;
            end else begin
              state_d = S_FILL;
            end
          end
        end
      end
      // push the upper half of the split block
      S_A_PUSH: begin
        lk_we       = 1'b1;
        lk_waddr    = FW'(CW'(a_q) + o_sz);
        lk_wdata    = head_word;
        hv_d[o_idx] = 1'b1;
        hf_d[o_idx] = FW'(CW'(a_q) + o_sz);
        state_d     = S_A_SPLIT;
      end
      S_A_DUP: begin
        dup_d   = (rc_rdata != '0);
        state_d = S_FILL;
      end
      S_FILL: begin
        if (fill_w < CW'(FRAMES)) begin
          rc_we    = 1'b1;
          rc_waddr = FW'(fill_w);
          rc_wdata = COUNT_W'(fval_q);
        end
        i_d = i_q + 1'b1;
        if (CW'(i_q) == order_sz - 1'b1) begin
          state_d = fret_q ? S_F_MERGE : S_FINISH;
        end
      end
      S_F_COW: begin
        if (rc_rdata > COUNT_W'(1)) begin
          rc_we    = 1'b1;
          rc_waddr = frame_idx;
          rc_wdata = rc_rdata - 1'b1;
          status_d = ST_DROP;
          state_d  = S_FINISH;
        end else if (rc_rdata == '0) begin
          status_d = ST_DFREE;
          state_d  = S_FINISH;
        end else begin
          state_d = S_F_REL;
        end
      end
      S_F_REL: begin
        a_d     = frame_idx;
        o_d     = OW'(order_q);
        total_d = t_add;
        if (cfg_i.rc_enable) begin
          i_d     = '0;
          fval_d  = 1'b0;
          fret_d  = 1'b1;
          state_d = S_FILL;
        end else begin
          state_d = S_F_MERGE;
        end
      end
      S_F_MERGE: begin
        if (o_q >= OW'(MAX_ORDER - 1)) begin
          state_d = S_PUSH;
        end else if (buddy < CW'(cfg_i.min_frame) ||
                     buddy + o_sz > CW'(cfg_i.max_frame)) begin
          state_d = S_PUSH;
        end else begin
          cur_d   = head_word;
          hprev_d = 1'b0;
          steps_d = '0;
          state_d = S_W_CHECK;
        end
      end
      S_W_CHECK: begin
        if (steps_q > SW'(FRAMES) || !cur_q[FW]) begin
          state_d = S_PUSH;
        end else begin
          lk_raddr = c_idx;
          state_d  = S_W_NEXT;
        end
      end
      S_W_NEXT: begin
        if (CW'(c_idx) == buddy) begin
          if (hprev_q) begin
            lk_we    = 1'b1;
            lk_waddr = prev_q;
            lk_wdata = lk_rdata;
          end else begin
            hv_d[o_idx] = lk_rdata[FW];
            hf_d[o_idx] = lk_rdata[FW-1:0];
          end
          if (buddy < CW'(a_q)) begin
            a_d = FW'(buddy);
          end
          o_d     = o_q + 1'b1;
          state_d = S_F_MERGE;
        end else begin
          prev_d  = c_idx;
          hprev_d = 1'b1;
          cur_d   = lk_rdata;
          steps_d = steps_q + 1'b1;
          state_d = S_W_CHECK;
        end
      end
      S_PUSH: begin
        lk_we       = 1'b1;
        lk_waddr    = a_q;
        lk_wdata    = head_word;
        hv_d[o_idx] = 1'b1;
        hf_d[o_idx] = a_q;
        status_d    = ST_DONE;
        state_d     = S_FINISH;
      end
      S_R_INC: begin
        if (rc_rdata != COUNT_MAX) begin
          rc_we    = 1'b1;
          rc_waddr = frame_idx;
          rc_wdata = rc_rdata + 1'b1;
        end
        status_d = ST_DONE;
        state_d  = S_FINISH;
      end
      S_R_RD: begin
        count_d = rc_rdata;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cmd_q    <= CMD_ALLOC;
      frame_q  <= '0; order_q <= '0; o_q <= '0; a_q <= '0;
      cur_q    <= '0; prev_q <= '0; hprev_q <= 1'b0; steps_q <= '0;
      i_q      <= '0; fval_q <= 1'b0; fret_q <= 1'b0;
      status_q <= ST_DONE; block_q <= '0; count_q <= '0; dup_q <= 1'b0;
      total_q  <= '0; clr_q <= '0; hv_q <= '0;
      for (int k = 0; k < MAX_ORDER; k++) begin
        hf_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      frame_q  <= frame_d; order_q <= order_d; o_q <= o_d; a_q <= a_d;
      cur_q    <= cur_d; prev_q <= prev_d; hprev_q <= hprev_d; steps_q <= steps_d;
      i_q      <= i_d; fval_q <= fval_d; fret_q <= fret_d;
      status_q <= status_d; block_q <= block_d; count_q <= count_d; dup_q <= dup_d;
      total_q  <= total_d; clr_q <= clr_d; hv_q <= hv_d;
      hf_q     <= hf_d;
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);

  always_comb begin
    res_o.status          = status_q;
    res_o.block_frame     = FRAME_W'(block_q);
    res_o.count_value     = count_q;
    res_o.free_frames     = total_q;
    res_o.duplicate_owner = dup_q;
  end
endmodule

// ===== rtl/core/buddy_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel     Dir  Payload                                                   Beat
// cmd_req_i   in   command[3] frame[18] order[4]                             valid & ready
// cmd_rsp_o   out  status[2] block_frame[18] count_value[16] free_frames[19]
//                  duplicate_owner[1]                                        valid & ready
// APB         in   min_frame @0x0, max_frame @0x4, refcount_enable @0x8      psel&penable&pwrite
//
// Operation: one command at a time through a sequencer around two single-port-read RAMs
// (list links and reference counts). Allocate scans upward past empty orders and splits
// the block down, then, with reference counting on, fills the counts of its 2^order frames
// and for a single frame first checks its count. Free fills the 2^order counts likewise
// and, per merge level, walks the list entries before the buddy is found.
// Reset: after rst_ni rises the count RAM is cleared one frame per cycle, all FRAMES frames,
// with cmd_req_i.ready low; APB writes are taken throughout.
// Stalls: the result sits in an output register, so a new command is taken while the
// previous result waits on cmd_rsp_o.ready.
module buddy_frame_allocator_unit #(
  parameter int unsigned FRAMES    = bfa_pkg::FRAMES_DEF,
  parameter int unsigned MAX_ORDER = bfa_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bfa_req_if.sink                     cmd_req_i,
  bfa_rsp_if.source                   cmd_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [bfa_pkg::DATA_W-1:0]  pwdata,
  output logic [bfa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bfa_pkg::*;

  // configuration registers
  cfg_t  cfg_q;
  reg_e  reg_sel;
  logic  cfg_wr;

  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_frame <= MIN_FRAME_RST;
      cfg_q.max_frame <= MAX_FRAME_RST;
      cfg_q.rc_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MIN_FRAME: cfg_q.min_frame <= pwdata[CFG_W-1:0];
        REG_MAX_FRAME: cfg_q.max_frame <= pwdata[CFG_W-1:0];
        REG_RC_ENABLE: cfg_q.rc_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_FRAME: prdata = DATA_W'(cfg_q.min_frame);
      REG_MAX_FRAME: prdata = DATA_W'(cfg_q.max_frame);
      REG_RC_ENABLE: prdata = DATA_W'(cfg_q.rc_enable);
      default:       prdata = '0;
    endcase
  end

  // sequencer
  cmd_t cmd;
  res_t res, res_q;
  logic res_valid, res_ready, out_valid_q;

  always_comb begin
    cmd.command = cmd_req_i.command;
    cmd.frame   = cmd_req_i.frame;
    cmd.order   = cmd_req_i.order;
  end

  bfa_engine #(.FRAMES(FRAMES), .MAX_ORDER(MAX_ORDER)) u_engine (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_req_i.valid),
    .cmd_ready_o (cmd_req_i.ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: load when empty or draining, hold otherwise
  assign res_ready = !out_valid_q || cmd_rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      res_q       <= res;
    end else if (cmd_rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign cmd_rsp_o.valid           = out_valid_q;
  assign cmd_rsp_o.status          = res_q.status;
  assign cmd_rsp_o.block_frame     = res_q.block_frame;
  assign cmd_rsp_o.count_value     = res_q.count_value;
  assign cmd_rsp_o.free_frames     = res_q.free_frames;
  assign cmd_rsp_o.duplicate_owner = res_q.duplicate_owner;

  // the sequencer never takes two commands back to back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_req_i.valid && cmd_req_i.ready) |=> !cmd_req_i.ready)
    else $error("command taken while sequencer busy");

  // a failed command leaves block_frame, count_value and duplicate_owner clear
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_rsp_o.valid && cmd_rsp_o.status == ST_FAIL) |->
      (cmd_rsp_o.block_frame == '0 && cmd_rsp_o.count_value == '0 &&
       !cmd_rsp_o.duplicate_owner))
    else $error("failed result carries data");

  // duplicate owner only comes with a successful allocation
  a_dup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_rsp_o.valid && cmd_rsp_o.duplicate_owner) |-> (cmd_rsp_o.status == ST_DONE))
    else $error("duplicate owner on unsuccessful result");
endmodule
